[hdl/matrix4_inverse_cofactor_top_macros.svh]
// ---------------------------------------------------------------------------
// matrix4_inverse_cofactor_top_macros
// Assertion macros used by the sequencer (m4i_ctrl) of the 4x4 matrix inverse block.
// ---------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_COFACTOR_TOP_MACROS_SVH
`define MATRIX4_INVERSE_COFACTOR_TOP_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define M4I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define M4I_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/m4i_pkg.sv]
// ---------------------------------------------------------------------------
// m4i_pkg
// Widths, command codes, controller/datapath structs and helper functions
// of the 4x4 matrix inverse block.
// ---------------------------------------------------------------------------
package m4i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int ELEM_W = 32;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int P_W    = 64;
  localparam int COF_W  = 98;
  localparam int ACC_W  = 132;
  localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W = $clog2(DIV_STEPS + 1);
  localparam int Q_W    = 34;

  typedef logic [3:0] op_t;
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_LATCH_A   = 4'd1;
  localparam op_t OP_MUL_P     = 4'd2;
  localparam op_t OP_MAC_PLO   = 4'd3;
  localparam op_t OP_MAC_PHI   = 4'd4;
  localparam op_t OP_STORE_COF = 4'd5;
  localparam op_t OP_MAC_DET   = 4'd6;
  localparam op_t OP_STORE_DET = 4'd7;
  localparam op_t OP_DIV_INIT  = 4'd8;
  localparam op_t OP_DIV_STEP  = 4'd9;
  localparam op_t OP_EMIT      = 4'd10;

  typedef struct packed {
    logic       wr;
    logic [3:0] wr_addr;
    logic       latch;
    logic       clr;
    logic [3:0] rd_addr;
    op_t        op;
    logic       neg;
    logic [1:0] chunk;
    logic [3:0] cof_idx;
    logic [3:0] out_idx;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       singular;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] x);
    return (i < x) ? i : i + 2'd1;
  endfunction

  // One of the six products of the 3x3 minor of element k, with its sign.
  function automatic term_t cof_term(input logic [3:0] k, input logic [2:0] t);
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] p0;
    logic [1:0] p1;
    logic [1:0] p2;
    logic       ps;
    term_t      tt;
    r = k[3:2];
    c = k[1:0];
    unique case (t)
      3'd1:    begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; ps = 1'b1; end
      3'd2:    begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; ps = 1'b1; end
      3'd3:    begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; ps = 1'b0; end
      3'd4:    begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; ps = 1'b0; end
      3'd5:    begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; ps = 1'b1; end
      default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; ps = 1'b0; end
    endcase
    tt.a   = {skip_idx(2'd0, r), skip_idx(p0, c)};
    tt.b   = {skip_idx(2'd1, r), skip_idx(p1, c)};
    tt.c   = {skip_idx(2'd2, r), skip_idx(p2, c)};
    tt.neg = ps ^ r[0] ^ c[0];
    return tt;
  endfunction

  function automatic logic [ACC_W-1:0] abs_w(input logic [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Clip a signed value to the WORD_BITS range, sign-extended to 32 bits.
  function automatic sat_t sat_w(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] hi;
    sat_t             s;
    hi = $signed(v) >>> (WORD_BITS - 1);
    if ((hi == '0) || (hi == '1)) begin
      s.val = v[31:0];
      s.sat = 1'b0;
    end else if (v[ACC_W-1]) begin
      s.val = {{(33 - WORD_BITS){1'b1}}, {(WORD_BITS - 1){1'b0}}};
      s.sat = 1'b1;
    end else begin
      s.val = {{(33 - WORD_BITS){1'b0}}, {(WORD_BITS - 1){1'b1}}};
      s.sat = 1'b1;
    end
    return s;
  endfunction

endpackage

[hdl/m4i_datapath.sv]
// ---------------------------------------------------------------------------
// m4i_datapath
// Element store, shared multiply-accumulate, cofactor registers, restoring
// divider and output register, all driven by the controller's commands.
// ---------------------------------------------------------------------------
module m4i_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_result_mode,
  input  logic signed [31:0] in_element_value,
  input  m4i_pkg::cmd_t      cmd,
  output m4i_pkg::sts_t      sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [3:0]         out_result_index,
  output logic               out_result_last,
  output logic               out_singular,
  output logic               out_saturated
);
  import m4i_pkg::*;

  logic [ELEM_W-1:0] mem [16];
  logic [ELEM_W-1:0] rd_r;
  logic [ELEM_W-1:0] opa_r;
  logic [P_W-1:0]    p_r;
  logic [ACC_W-1:0]  acc_r;
  logic [COF_W-1:0]  cof_r [16];
  logic [ACC_W-1:0]  det_r;
  logic [ACC_W-1:0]  dm_r;
  logic [NUM_W-1:0]  num_r;
  logic [ACC_W:0]    rem_r;
  logic [Q_W-1:0]    q_r;
  logic              qneg_r;
  logic [1:0]        mode_r;
  logic [1:0]        mode_q_r;
  logic              out_valid_r;
  logic [31:0]       out_value_r;
  logic [3:0]        out_index_r;
  logic              out_last_r;
  logic              out_sing_r;
  logic              out_sat_r;

  logic [ELEM_W-1:0]        wdata;
  logic [COF_W-1:0]         cof_rd;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         addend;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         cof_sx;
  logic [ACC_W-1:0]         cof_mag;
  logic [ACC_W-1:0]         adj_mag;
  logic [ACC_W-1:0]         det_mag;
  logic [ACC_W-1:0]         q_val;
  logic [ACC_W-1:0]         emit_raw;
  logic [ACC_W:0]           rem_sh;
  logic                     ge;
  logic                     singular;
  sat_t                     emit_s;

  assign wdata   = ELEM_W'(signed'(in_element_value[WORD_BITS-1:0]));
  assign cof_rd  = cof_r[cmd.cof_idx];
  assign cof_sx  = ACC_W'(signed'(cof_rd));
  assign cof_mag = abs_w(cof_sx);
  assign singular = (det_r == '0);

  always_comb begin
    mul_a = MUL_W'(signed'(rd_r));
    mul_b = MUL_W'(signed'(rd_r));
    unique case (cmd.op)
      OP_MUL_P:   mul_a = MUL_W'(signed'(opa_r));
      OP_MAC_PLO: mul_a = {1'b0, p_r[31:0]};
      OP_MAC_PHI: mul_a = MUL_W'(signed'(p_r[63:32]));
      OP_MAC_DET: begin
        unique case (cmd.chunk)
          2'd0: mul_b = {1'b0, cof_rd[31:0]};
          2'd1: mul_b = {1'b0, cof_rd[63:32]};
          2'd2: mul_b = {1'b0, cof_rd[95:64]};
          2'd3: mul_b = MUL_W'(signed'(cof_rd[COF_W-1:96]));
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign addend  = ACC_W'(prod) << {cmd.chunk, 5'd0};
  assign acc_nxt = cmd.neg ? (acc_r - addend) : (acc_r + addend);

  assign rem_sh = {rem_r[ACC_W-1:0], num_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dm_r});

  // Results truncate toward zero: shift the magnitude, then restore the sign.
  assign adj_mag = cof_mag >> (2 * FRAC_BITS);
  assign det_mag = abs_w(det_r) >> (3 * FRAC_BITS);
  assign q_val   = qneg_r ? (~ACC_W'(q_r) + 1'b1) : ACC_W'(q_r);

  always_comb begin
    if (mode_q_r[1]) begin
      emit_raw = det_r[ACC_W-1] ? (~det_mag + 1'b1) : det_mag;
    end else if (mode_q_r[0]) begin
      emit_raw = cof_sx[ACC_W-1] ? (~adj_mag + 1'b1) : adj_mag;
    end else if (singular) begin
      emit_raw = '0;
    end else begin
      emit_raw = q_val;
    end
  end

  assign emit_s = sat_w(emit_raw);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.wr_addr] <= wdata;
    end
    rd_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 2'd0;
      mode_q_r <= 2'd0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_result_mode;
      end
      if (cmd.latch) begin
        mode_q_r <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      acc_r <= '0;
    end
    unique case (cmd.op)
      OP_LATCH_A:   opa_r <= rd_r;
      OP_MUL_P:     p_r <= prod[P_W-1:0];
      OP_MAC_PLO,
      OP_MAC_PHI,
      OP_MAC_DET:   acc_r <= acc_nxt;
      OP_STORE_COF: begin
        cof_r[cmd.cof_idx] <= acc_r[COF_W-1:0];
        acc_r <= '0;
      end
      OP_STORE_DET: det_r <= acc_r;
      OP_DIV_INIT:  begin
        num_r  <= {cof_mag[COF_W-1:0], {(2 * FRAC_BITS){1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
        qneg_r <= cof_sx[ACC_W-1] ^ det_r[ACC_W-1];
        dm_r   <= abs_w(det_r);
      end
      OP_DIV_STEP:  begin
        rem_r <= ge ? (rem_sh - {1'b0, dm_r}) : rem_sh;
        num_r <= num_r << 1;
        // Top quotient bit is sticky: anything that large saturates anyway.
        q_r   <= {q_r[Q_W-1] | q_r[Q_W-2], q_r[Q_W-3:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_value_r <= emit_s.val;
      out_index_r <= cmd.out_idx;
      out_last_r  <= cmd.out_last;
      out_sing_r  <= singular;
      out_sat_r   <= emit_s.sat;
    end
  end

  assign sts.mode     = mode_q_r;
  assign sts.singular = singular;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_value = signed'(out_value_r);
  assign out_result_index = out_index_r;
  assign out_result_last  = out_last_r;
  assign out_singular     = out_sing_r;
  assign out_saturated    = out_sat_r;

endmodule

[hdl/m4i_ctrl.sv]
// ---------------------------------------------------------------------------
// m4i_ctrl
// Sequencer: loads sixteen elements, steps the cofactor, determinant,
// divide and emit phases, and issues one datapath command per cycle.
// ---------------------------------------------------------------------------
`include "matrix4_inverse_cofactor_top_macros.svh"

module m4i_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  m4i_pkg::sts_t sts,
  output m4i_pkg::cmd_t cmd
);
  import m4i_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_COF    = 3'd1;
  localparam logic [2:0] S_COFST  = 3'd2;
  localparam logic [2:0] S_DET    = 3'd3;
  localparam logic [2:0] S_DETST  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [2:0]        c_r, c_nxt;
  logic [DCNT_W-1:0] d_r, d_nxt;
  term_t             term;

  assign term     = cof_term(k_r, t_r);
  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.wr      = 1'b1;
          cmd.wr_addr = cnt_r;
          cnt_nxt     = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            cmd.latch = 1'b1;
            cmd.clr   = 1'b1;
            k_nxt     = 4'd0;
            t_nxt     = 3'd0;
            c_nxt     = 3'd0;
            state_nxt = S_COF;
          end
        end
      end
      S_COF: begin
        cmd.neg = term.neg;
        unique case (c_r)
          3'd0:    begin cmd.rd_addr = term.a; cmd.op = OP_NOP; end
          3'd1:    begin cmd.rd_addr = term.b; cmd.op = OP_LATCH_A; end
          3'd2:    begin cmd.rd_addr = term.c; cmd.op = OP_MUL_P; end
          3'd3:    begin cmd.rd_addr = term.c; cmd.op = OP_MAC_PLO; end
          default: begin
            cmd.rd_addr = term.c;
            cmd.op      = OP_MAC_PHI;
            cmd.chunk   = 2'd1;
          end
        endcase
        if (c_r == 3'd4) begin
          c_nxt = 3'd0;
          if (t_r == 3'd5) begin
            state_nxt = S_COFST;
          end else begin
            t_nxt = t_r + 3'd1;
          end
        end else begin
          c_nxt = c_r + 3'd1;
        end
      end
      S_COFST: begin
        cmd.op      = OP_STORE_COF;
        cmd.cof_idx = k_r;
        t_nxt       = 3'd0;
        if (k_r == 4'd15) begin
          k_nxt     = 4'd0;
          state_nxt = S_DET;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_COF;
        end
      end
      S_DET: begin
        // Row 0 element times its cofactor, one slice (32 bits, the top one 2 bits) a cycle.
        cmd.rd_addr = k_r;
        cmd.cof_idx = k_r;
        if (c_r != 3'd0) begin
          cmd.op    = OP_MAC_DET;
          cmd.chunk = 2'(c_r - 3'd1);
        end
        if (c_r == 3'd4) begin
          c_nxt = 3'd0;
          if (k_r == 4'd3) begin
            state_nxt = S_DETST;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          c_nxt = c_r + 3'd1;
        end
      end
      S_DETST: begin
        cmd.op    = OP_STORE_DET;
        k_nxt     = 4'd0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.cof_idx = {k_r[1:0], k_r[3:2]};
        if (!sts.mode[1] && !sts.mode[0] && !sts.singular) begin
          cmd.op    = OP_DIV_INIT;
          d_nxt     = '0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        d_nxt  = d_r + 1'b1;
        if (d_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      default: begin
        cmd.cof_idx  = {k_r[1:0], k_r[3:2]};
        cmd.out_idx  = sts.mode[1] ? 4'd0 : k_r;
        cmd.out_last = sts.mode[1] || (k_r == 4'd15);
        if (sts.out_free) begin
          cmd.op = OP_EMIT;
          if (cmd.out_last) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_OUT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= 4'd0;
      k_r     <= 4'd0;
      t_r     <= 3'd0;
      c_r     <= 3'd0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
    end
  end

  `M4I_ASSERT(a_emit_free, (cmd.op == OP_EMIT) |-> sts.out_free, "emit while output held")
  `M4I_ASSERT(a_last_load, (in_valid && in_ready && cnt_r == 4'd15) |=> (state_r == S_COF), "sixteenth element did not start compute")
  `M4I_ASSERT(a_div_exit, (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_EMIT), "divider left early")
  `M4I_ASSERT_RST(a_reset, !rst_n |=> (state_r == S_LOAD && cnt_r == 4'd0), "reset did not clear sequencer")

endmodule

[hdl/matrix4_inverse_cofactor_top.sv]
// ---------------------------------------------------------------------------
// matrix4_inverse_cofactor_top
// 4x4 signed Q16.16 matrix inverse, adjugate or determinant by cofactors.
// ---------------------------------------------------------------------------
// Usage: feed sixteen elements on in_* in row-major order (valid/ready).
// Loading accepts one element per cycle. After the sixteenth the block stops
// taking input, forms the sixteen cofactors with one shared 33x33 multiplier
// and the determinant, then emits. Emission: mode 2 or 3 gives one result;
// mode 1 gives sixteen; mode 0 runs a one-bit-a-cycle restoring divider per
// element (zero determinant: no divide, each result is zero).
// out_* holds each result in a register until taken; a stalled receiver
// holds the sequencer. After the final result is registered, loading of
// the next matrix starts while that result still waits.
// cfg_* writes result_mode (always ready); it is sampled at the sixteenth
// element. Reset (rst_n low, synchronous) empties the element count, sets
// mode 0 and drops any pending result.
// ---------------------------------------------------------------------------
module matrix4_inverse_cofactor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_result_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [3:0]         out_result_index,
  output logic               out_result_last,
  output logic               out_singular,
  output logic               out_saturated
);
  import m4i_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  m4i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  m4i_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_result_mode  (cfg_result_mode),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_result_last  (out_result_last),
    .out_singular     (out_singular),
    .out_saturated    (out_saturated)
  );

endmodule
